/* src/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the middle-pop queue: command and response
// items, command codes, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_STATUS = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int OUT_WIDTH   = 32;
  localparam int COUNT_WIDTH = 5;

  // input item
  typedef struct packed {
    logic [1:0]                  command;
    logic signed [OUT_WIDTH-1:0] push_value;
  } cmd_item_t;

  // result item
  typedef struct packed {
    logic [1:0]                  status;
    logic signed [OUT_WIDTH-1:0] popped_value;
    logic                        middle_valid;
    logic signed [OUT_WIDTH-1:0] middle_value;
    logic [COUNT_WIDTH-1:0]      item_count;
  } rsp_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic do_push;
    logic full_err;
    logic do_pop_rd;
    logic empty_err;
    logic cap_pop;
    logic do_clear;
    logic fifo_rd;
    logic do_move;
    logic mid_rd;
    logic load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       empty;
    logic       need_move;
    logic       out_free;
  } stat_t;

endpackage

/* src/middle_pop_queue_core.sv */
// ----------------------------------------------------------------------------
// middle_pop_queue_core
// Bounded queue that takes items at the back and gives them out from the
// middle; a stack holds the lower half and a circular fifo the upper half.
// ----------------------------------------------------------------------------
//  channel   signals                          item
//  --------  -------------------------------  ---------------------------
//  command   cmd_valid / cmd_ready / cmd      command, push_value
//  response  rsp_valid / rsp_ready / rsp      status, popped value, middle,
//                                             item count
//
// The sequencer steps a command through single-port accesses of the stack
// and fifo (pop read, rebalance read and write, middle read): status, clear
// or a refused command only read the middle, a push may rebalance, and a pop
// reads the top and may rebalance. The next command can be accepted in the
// cycle after the result is loaded.
// A finished result sits in the output register; the next command is taken
// while it waits, but its result is held back until the register frees.
// Reset is synchronous and empties the queue at once.
module middle_pop_queue_core #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  mpq_pkg::cmd_item_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output mpq_pkg::rsp_item_t rsp
);

  mpq_pkg::ctrl_t ctrl;
  mpq_pkg::stat_t stat;

  // sequencer
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // storage and result register
  mpq_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .ctrl      (ctrl),
    .stat      (stat)
  );

endmodule

/* src/mpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for the middle-pop queue: steps one command through its memory
// accesses (update, optional rebalance move, middle read) and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module mpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mpq_pkg::stat_t stat,
  output mpq_pkg::ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POPRD = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_RDMID = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctrl.latch_in = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.command)
          mpq_pkg::CMD_PUSH: begin
            if (stat.full) begin
              ctrl.full_err = 1'b1;
              state_next    = S_RDMID;
            end else begin
              ctrl.do_push = 1'b1;
              state_next   = S_CHK;
            end
          end
          mpq_pkg::CMD_POP: begin
            if (stat.empty) begin
              ctrl.empty_err = 1'b1;
              state_next     = S_RDMID;
            end else begin
              ctrl.do_pop_rd = 1'b1;
              state_next     = S_POPRD;
            end
          end
          mpq_pkg::CMD_CLEAR: begin
            ctrl.do_clear = 1'b1;
            state_next    = S_RDMID;
          end
          default: begin
            state_next = S_RDMID;
          end
        endcase
      end
      S_POPRD: begin
        ctrl.cap_pop = 1'b1;
        state_next   = S_CHK;
      end
      S_CHK: begin
        if (stat.need_move) begin
          ctrl.fifo_rd = 1'b1;
          state_next   = S_MOVE;
        end else begin
          state_next = S_RDMID;
        end
      end
      S_MOVE: begin
        ctrl.do_move = 1'b1;
        state_next   = S_RDMID;
      end
      S_RDMID: begin
        ctrl.mid_rd = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/mpq_datapath.sv */
// ----------------------------------------------------------------------------
// mpq_datapath
// Storage and counters of the middle-pop queue: the lower-half stack, the
// upper-half circular fifo, their counts, the fifo head and the result
// register.
// ----------------------------------------------------------------------------
module mpq_datapath #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mpq_pkg::cmd_item_t   cmd,
  input  logic                 rsp_ready,
  output logic                 rsp_valid,
  output mpq_pkg::rsp_item_t   rsp,
  input  mpq_pkg::ctrl_t       ctrl,
  output mpq_pkg::stat_t       stat
);

  localparam int HALF = (CAPACITY + 1) / 2;
  localparam int IW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CW   = $clog2(HALF + 1);
  localparam int TW   = $clog2(2 * HALF + 1);

  localparam int OUT_WIDTH_L = mpq_pkg::OUT_WIDTH;

  logic [VALUE_WIDTH-1:0] lower_stack [HALF];
  logic [VALUE_WIDTH-1:0] upper_fifo  [HALF];

  logic [CW-1:0]          lower_count;
  logic [CW-1:0]          upper_count;
  logic [IW-1:0]          upper_head;

  logic [1:0]             command;
  logic [VALUE_WIDTH-1:0] value;
  logic [1:0]             status;
  logic [OUT_WIDTH_L-1:0] popped;
  logic [VALUE_WIDTH-1:0] stack_rd;
  logic [VALUE_WIDTH-1:0] fifo_rd;

  logic [TW-1:0]          total;
  logic [IW:0]            tail_sum;
  logic [IW-1:0]          tail_idx;
  logic [IW-1:0]          head_inc;
  logic [IW-1:0]          lower_idx;
  logic [IW-1:0]          top_idx;
  logic [CW-1:0]          lower_dec;

  // sign-extend a stored value to the output width
  function automatic logic [OUT_WIDTH_L-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] ext;
    ext    = 64'(signed'(v));
    to_out = ext[OUT_WIDTH_L-1:0];
  endfunction

  // address arithmetic
  always_comb begin
    total     = TW'(lower_count) + TW'(upper_count);
    tail_sum  = (IW + 1)'(upper_head) + (IW + 1)'(upper_count);
    if (tail_sum >= (IW + 1)'(HALF)) begin
      tail_sum = tail_sum - (IW + 1)'(HALF);
    end
    tail_idx  = tail_sum[IW-1:0];
    head_inc  = (upper_head == IW'(HALF - 1)) ? '0 : upper_head + IW'(1);
    lower_idx = lower_count[IW-1:0];
    lower_dec = lower_count - CW'(1);
    top_idx   = lower_dec[IW-1:0];
  end

  // status to the controller
  always_comb begin
    stat.command   = command;
    stat.full      = (total >= TW'(CAPACITY)) || (upper_count >= CW'(HALF));
    stat.empty     = (lower_count == '0);
    stat.need_move = (upper_count > lower_count) && (lower_count < CW'(HALF));
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  // fifo memory: write at the tail, read at the head
  always_ff @(posedge clk) begin
    if (ctrl.do_push) begin
      upper_fifo[tail_idx] <= value;
    end
    if (ctrl.fifo_rd) begin
      fifo_rd <= upper_fifo[upper_head];
    end
  end

  // stack memory: write on a move, read the top
  always_ff @(posedge clk) begin
    if (ctrl.do_move) begin
      lower_stack[lower_idx] <= fifo_rd;
    end
    if (ctrl.do_pop_rd || ctrl.mid_rd) begin
      stack_rd <= lower_stack[top_idx];
    end
  end

  // latched command and per-item result fields
  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      command <= cmd.command;
      value   <= VALUE_WIDTH'(cmd.push_value);
      status  <= mpq_pkg::ST_OK;
      popped  <= '0;
    end
    if (ctrl.full_err) begin
      status <= mpq_pkg::ST_FULL;
    end
    if (ctrl.empty_err) begin
      status <= mpq_pkg::ST_EMPTY;
    end
    if (ctrl.cap_pop) begin
      popped <= to_out(stack_rd);
    end
  end

  // counters and fifo head
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
      upper_head  <= '0;
    end else if (ctrl.do_clear) begin
      lower_count <= '0;
      upper_count <= '0;
      upper_head  <= '0;
    end else if (ctrl.do_push) begin
      upper_count <= upper_count + CW'(1);
    end else if (ctrl.do_pop_rd) begin
      lower_count <= lower_dec;
    end else if (ctrl.do_move) begin
      lower_count <= lower_count + CW'(1);
      upper_count <= upper_count - CW'(1);
      upper_head  <= head_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      rsp.status       <= status;
      rsp.popped_value <= popped;
      rsp.middle_valid <= !stat.empty;
      rsp.middle_value <= stat.empty ? '0 : to_out(stack_rd);
      rsp.item_count   <= mpq_pkg::COUNT_WIDTH'(total);
    end
  end

endmodule

/* src/mpq_checker.sv */
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks for the middle-pop queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input mpq_pkg::cmd_item_t cmd,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input mpq_pkg::rsp_item_t rsp
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  // empty queue shows no middle and no items
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.middle_valid |-> rsp.middle_value == 0 && rsp.item_count == 0)
    else $error("empty result carries data");

  // refused commands pop nothing
  a_refused: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != mpq_pkg::ST_OK |-> rsp.popped_value == 0)
    else $error("refused command popped a value");

  // a pop refused on empty leaves the queue empty
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == mpq_pkg::ST_EMPTY |-> !rsp.middle_valid)
    else $error("empty refusal with items held");

endmodule

bind middle_pop_queue_core mpq_checker u_mpq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
